>>> src/gnpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnpc_pkg
// Types, constants and elaboration-time helpers shared by the gradient noise
// pixel colorizer: payload words, register map, hash constants, sine table.
// ----------------------------------------------------------------------------
package gnpc_pkg;

    // field widths
    localparam int unsigned PIX_FIELD_W = 12;
    localparam int unsigned LAT_W       = 24;
    localparam int unsigned SIZE_W      = 13;
    localparam int unsigned ZOOM_W      = 16;
    localparam int unsigned SEED_W      = 32;
    localparam int unsigned LEVEL_W     = 8;
    localparam int unsigned COLOR_W     = 8;
    localparam int unsigned ANGLE_W     = 9;
    localparam int unsigned SIN_IDX_W   = 7;
    localparam int unsigned SIN_LAST    = 90;

    // configuration port
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_ZOOM         = 3'd2,
        REG_HASH_SEED    = 3'd3,
        REG_RED_LEVEL    = 3'd4,
        REG_GREEN_LEVEL  = 3'd5,
        REG_BLUE_LEVEL   = 3'd6
    } t_reg_idx;

    localparam logic [SIZE_W-1:0]  RST_IMAGE_WIDTH  = 13'd256;
    localparam logic [SIZE_W-1:0]  RST_IMAGE_HEIGHT = 13'd256;
    localparam logic [ZOOM_W-1:0]  RST_ZOOM         = 16'd2048;
    localparam logic [SEED_W-1:0]  RST_HASH_SEED    = 32'd0;
    localparam logic [LEVEL_W-1:0] RST_LEVEL        = 8'd255;

    // corner hash
    localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
    localparam logic [31:0] HASH_MIX     = 32'd1274126177;
    localparam int unsigned HASH_SHIFT_A = 13;
    localparam int unsigned HASH_SHIFT_B = 16;

    // modulo 360 by reciprocal, floor(2^40 / 360) - 1
    localparam logic [31:0]        MOD360_RECIP = 32'd3054198965;
    localparam int unsigned        MOD360_SHIFT = 40;
    localparam logic [ANGLE_W-1:0] DEG_FULL     = 9'd360;
    localparam logic [ANGLE_W-1:0] DEG_HALF     = 9'd180;
    localparam logic [ANGLE_W-1:0] DEG_3Q       = 9'd270;
    localparam logic [ANGLE_W-1:0] DEG_QUARTER  = 9'd90;

    // latency of one corner unit
    localparam int unsigned CORNER_LAT = 9;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef struct packed {
        logic [PIX_FIELD_W-1:0] pixel_x;
        logic [PIX_FIELD_W-1:0] pixel_y;
    } t_pixel;

    typedef struct packed {
        logic [COLOR_W-1:0] red_out;
        logic [COLOR_W-1:0] green_out;
        logic [COLOR_W-1:0] blue_out;
    } t_result;

    // lattice coordinate, unsigned 8.16
    typedef struct packed {
        logic [LAT_W-1:0] coord_x;
        logic [LAT_W-1:0] coord_y;
    } t_lat;

    typedef struct packed {
        logic [SIZE_W-1:0]  image_width;
        logic [SIZE_W-1:0]  image_height;
        logic [ZOOM_W-1:0]  zoom_q8_8;
        logic [SEED_W-1:0]  hash_seed;
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
    } t_cfg;

    typedef struct packed {
        logic                 neg;
        logic [SIN_IDX_W-1:0] idx;
    } t_sin_sel;

    // quadrant folding of a whole-degree angle below 360
    function automatic t_sin_sel sin_select(input logic [ANGLE_W-1:0] ang);
        t_sin_sel     sel;
        logic [ANGLE_W-1:0] k;
        if (ang <= DEG_QUARTER) begin
            k = ang;
            sel.neg = 1'b0;
        end else if (ang <= DEG_HALF) begin
            k = DEG_HALF - ang;
            sel.neg = 1'b0;
        end else if (ang <= DEG_3Q) begin
            k = ang - DEG_HALF;
            sel.neg = 1'b1;
        end else begin
            k = DEG_FULL - ang;
            sel.neg = 1'b1;
        end
        sel.idx = k[SIN_IDX_W-1:0];
        return sel;
    endfunction

    // sine of k degrees in unsigned Q30, Taylor series through x^13
    function automatic longint unsigned sin_q30(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned prod;
        x = (64'(k) * PI_Q30) / 64'd180;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int n = 1; n <= 6; n++) begin
            prod = (term * x2) >> 30;
            case (n)
                1: term = prod / 64'd6;
                2: term = prod / 64'd20;
                3: term = prod / 64'd42;
                4: term = prod / 64'd72;
                5: term = prod / 64'd110;
                default: term = prod / 64'd156;
            endcase
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // sine magnitude rounded half up to frac bits, saturated below one
    function automatic longint unsigned sin_fixed(input int unsigned k,
                                                  input int unsigned frac);
        longint unsigned r;
        longint unsigned lim;
        r = (sin_q30(k) + (64'd1 << (29 - frac))) >> (30 - frac);
        lim = (64'd1 << frac) - 64'd1;
        if (r > lim) begin
            r = lim;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/gnpc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnpc_fifo
// Small register queue with show-ahead read, used between the scaling front
// and the noise back end and as the result queue.
// ----------------------------------------------------------------------------
module gnpc_fifo #(
    parameter int unsigned W     = 48,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

>>> src/gnpc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnpc_front
// Scales a pixel to lattice space: pixel * zoom << 8 / size for both axes,
// a multiply stage then a pipelined restoring divider, two bits per stage.
// ----------------------------------------------------------------------------
module gnpc_front #(
    parameter int unsigned COORD_BITS = 12
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire gnpc_pkg::t_pixel i_pixel,
    input  wire gnpc_pkg::t_cfg  i_cfg,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output gnpc_pkg::t_lat       o_lat
);
    localparam int unsigned PIX_W  = (COORD_BITS < gnpc_pkg::PIX_FIELD_W) ?
                                     COORD_BITS : gnpc_pkg::PIX_FIELD_W;
    localparam int unsigned PROD_W = PIX_W + gnpc_pkg::ZOOM_W;
    localparam int unsigned NUM_W  = PROD_W + 8;
    localparam int unsigned STAGES = (NUM_W + 1) / 2;
    localparam int unsigned PAD_W  = 2 * STAGES;
    localparam int unsigned REM_W  = gnpc_pkg::SIZE_W;

    logic              r_v [0:STAGES];
    logic [PROD_W-1:0] r_prod_x;
    logic [PROD_W-1:0] r_prod_y;
    logic [REM_W-1:0]  r_rem_x [1:STAGES];
    logic [REM_W-1:0]  r_rem_y [1:STAGES];
    logic [PAD_W-1:0]  r_nq_x  [1:STAGES];
    logic [PAD_W-1:0]  r_nq_y  [1:STAGES];
    logic [REM_W-1:0]  n_rem_x [1:STAGES];
    logic [REM_W-1:0]  n_rem_y [1:STAGES];
    logic [PAD_W-1:0]  n_nq_x  [1:STAGES];
    logic [PAD_W-1:0]  n_nq_y  [1:STAGES];
    logic [REM_W-1:0]  div_x;
    logic [REM_W-1:0]  div_y;
    logic              en;

    // two restoring steps: remainder in, next numerator bits out, quotient in
    function automatic logic [REM_W+PAD_W-1:0] div2(input logic [REM_W-1:0] rem,
                                                    input logic [PAD_W-1:0] nq,
                                                    input logic [REM_W-1:0] d);
        logic [REM_W:0]   t;
        logic [REM_W-1:0] r;
        logic [PAD_W-1:0] q;
        r = rem;
        q = nq;
        for (int b = 0; b < 2; b++) begin
            t = {r, q[PAD_W-1]};
            q = {q[PAD_W-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                t = t - {1'b0, d};
                q[0] = 1'b1;
            end
            r = t[REM_W-1:0];
        end
        return {r, q};
    endfunction

    // zero size divides as one
    assign div_x = (i_cfg.image_width == '0) ? REM_W'(1) : i_cfg.image_width;
    assign div_y = (i_cfg.image_height == '0) ? REM_W'(1) : i_cfg.image_height;

    assign en      = !r_v[STAGES] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[STAGES];
    assign o_lat.coord_x = r_nq_x[STAGES][gnpc_pkg::LAT_W-1:0];
    assign o_lat.coord_y = r_nq_y[STAGES][gnpc_pkg::LAT_W-1:0];

    // divider stage logic
    always_comb begin
        logic [REM_W+PAD_W-1:0] sx;
        logic [REM_W+PAD_W-1:0] sy;
        for (int s = 1; s <= STAGES; s++) begin
            if (s == 1) begin
                sx = div2('0, PAD_W'({r_prod_x, 8'b0}), div_x);
                sy = div2('0, PAD_W'({r_prod_y, 8'b0}), div_y);
            end else begin
                sx = div2(r_rem_x[s-1], r_nq_x[s-1], div_x);
                sy = div2(r_rem_y[s-1], r_nq_y[s-1], div_y);
            end
            n_rem_x[s] = sx[REM_W+PAD_W-1:PAD_W];
            n_nq_x[s]  = sx[PAD_W-1:0];
            n_rem_y[s] = sy[REM_W+PAD_W-1:PAD_W];
            n_nq_y[s]  = sy[PAD_W-1:0];
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod_x <= PROD_W'(i_pixel.pixel_x[PIX_W-1:0]) * PROD_W'(i_cfg.zoom_q8_8);
            r_prod_y <= PROD_W'(i_pixel.pixel_y[PIX_W-1:0]) * PROD_W'(i_cfg.zoom_q8_8);
            for (int s = 1; s <= STAGES; s++) begin
                r_rem_x[s] <= n_rem_x[s];
                r_rem_y[s] <= n_rem_y[s];
                r_nq_x[s]  <= n_nq_x[s];
                r_nq_y[s]  <= n_nq_y[s];
            end
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= STAGES; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= STAGES; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

endmodule
`default_nettype wire

>>> src/gnpc_corner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnpc_corner
// One lattice corner: hash of cell and seed, angle mod 360, gradient from the
// sine table, dot product with the corner offset. Fixed nine-stage pipe.
// ----------------------------------------------------------------------------
module gnpc_corner #(
    parameter int unsigned FRAC_BITS = 15
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [8:0]         i_cell_x,
    input  wire logic [8:0]         i_cell_y,
    input  wire logic signed [16:0] i_dx,
    input  wire logic signed [16:0] i_dy,
    input  wire logic [31:0]        i_seed,
    output logic signed [FRAC_BITS+2:0] o_dot
);
    localparam int unsigned G_W  = FRAC_BITS + 1;
    localparam int unsigned P_W  = G_W + 17;
    localparam int unsigned D_W  = FRAC_BITS + 3;
    localparam int unsigned DL   = 7;
    localparam int unsigned AW   = gnpc_pkg::ANGLE_W;

    logic [FRAC_BITS-1:0] sin_tab [0:gnpc_pkg::SIN_LAST];

    logic [31:0]            r_hx;
    logic [31:0]            r_hy;
    logic [31:0]            r_h1;
    logic [31:0]            r_h2;
    logic [31:0]            r_h3;
    logic [23:0]            r_q;
    logic [9:0]             r_r;
    logic [AW-1:0]          r_ang_s;
    logic [AW-1:0]          r_ang_c;
    logic signed [G_W-1:0]  r_gx;
    logic signed [G_W-1:0]  r_gy;
    logic signed [P_W-1:0]  r_px;
    logic signed [P_W-1:0]  r_py;
    logic signed [16:0]     r_dx [1:DL];
    logic signed [16:0]     r_dy [1:DL];
    logic signed [D_W-1:0]  r_dot;

    logic [31:0]            h_sum;
    logic [31:0]            h_mix;
    logic [63:0]            q_prod;
    logic [31:0]            r_full;
    logic [AW-1:0]          ang;
    logic [AW-1:0]          ang90;
    gnpc_pkg::t_sin_sel     sel_s;
    gnpc_pkg::t_sin_sel     sel_c;
    logic signed [G_W-1:0]  g_s;
    logic signed [G_W-1:0]  g_c;
    logic signed [P_W:0]    dot_sum;

    // sine quarter wave, folded at elaboration
    for (genvar k = 0; k <= gnpc_pkg::SIN_LAST; k++) begin : g_sin
        assign sin_tab[k] = FRAC_BITS'(gnpc_pkg::sin_fixed(k, FRAC_BITS));
    end

    // hash mixing, angle reduction, gradient selection and dot sum
    always_comb begin
        h_sum  = r_hx + r_hy + i_seed;
        h_mix  = r_h2 ^ (r_h2 >> gnpc_pkg::HASH_SHIFT_B);
        q_prod = 64'(h_mix) * 64'(gnpc_pkg::MOD360_RECIP);
        r_full = r_h3 - (32'(r_q) * 32'(gnpc_pkg::DEG_FULL));
        ang    = (r_r >= 10'(gnpc_pkg::DEG_FULL)) ?
                 AW'(r_r - 10'(gnpc_pkg::DEG_FULL)) : AW'(r_r);
        ang90  = ang + gnpc_pkg::DEG_QUARTER;
        if (ang90 >= gnpc_pkg::DEG_FULL) begin
            ang90 = ang90 - gnpc_pkg::DEG_FULL;
        end
        sel_s = gnpc_pkg::sin_select(r_ang_s);
        sel_c = gnpc_pkg::sin_select(r_ang_c);
        g_s   = sel_s.neg ? -$signed({1'b0, sin_tab[sel_s.idx]}) :
                             $signed({1'b0, sin_tab[sel_s.idx]});
        g_c   = sel_c.neg ? -$signed({1'b0, sin_tab[sel_c.idx]}) :
                             $signed({1'b0, sin_tab[sel_c.idx]});
        dot_sum = (P_W+1)'(r_px) + (P_W+1)'(r_py);
    end

    // pipe stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hx    <= 32'(i_cell_x) * gnpc_pkg::HASH_MUL_X;
            r_hy    <= 32'(i_cell_y) * gnpc_pkg::HASH_MUL_Y;
            r_h1    <= h_sum ^ (h_sum >> gnpc_pkg::HASH_SHIFT_A);
            r_h2    <= r_h1 * gnpc_pkg::HASH_MIX;
            r_h3    <= h_mix;
            r_q     <= q_prod[gnpc_pkg::MOD360_SHIFT +: 24];
            r_r     <= r_full[9:0];
            r_ang_s <= ang;
            r_ang_c <= ang90;
            r_gx    <= g_c;
            r_gy    <= g_s;
            r_px    <= r_gx * r_dx[DL];
            r_py    <= r_gy * r_dy[DL];
            r_dot   <= D_W'(dot_sum >>> 16);
            r_dx[1] <= i_dx;
            r_dy[1] <= i_dy;
            for (int i = 2; i <= DL; i++) begin
                r_dx[i] <= r_dx[i-1];
                r_dy[i] <= r_dy[i-1];
            end
        end
    end

    assign o_dot = r_dot;

endmodule
`default_nettype wire

>>> src/gnpc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnpc_back
// Noise back end: four corner units, smoothstep weights, bilinear blend and
// the colour mapping, as one stall-together pipeline.
// ----------------------------------------------------------------------------
module gnpc_back #(
    parameter int unsigned FRAC_BITS = 15
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_pop,
    input  wire gnpc_pkg::t_lat   i_lat,
    input  wire gnpc_pkg::t_cfg   i_cfg,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output gnpc_pkg::t_result     o_result
);
    localparam int unsigned CL   = gnpc_pkg::CORNER_LAT;
    localparam int unsigned LAST = CL + 6;
    localparam int unsigned SD   = CL - 1;
    localparam int unsigned D_W  = FRAC_BITS + 3;
    localparam int unsigned M_W  = D_W + 18;
    localparam int unsigned CH_W = D_W + 10;
    localparam logic signed [D_W:0] NOISE_ONE =
        {{(D_W - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [gnpc_pkg::COLOR_W-1:0] COLOR_MAX = '1;

    logic                 r_v [0:LAST];
    gnpc_pkg::t_lat       r_lat;
    logic [31:0]          r_ttx;
    logic [31:0]          r_tty;
    logic [15:0]          r_tx1;
    logic [15:0]          r_ty1;
    logic [31:0]          r_s [0:SD-1];
    logic signed [M_W-1:0] r_pt;
    logic signed [M_W-1:0] r_pb;
    logic signed [D_W-1:0] r_at;
    logic signed [D_W-1:0] r_ab;
    logic [15:0]          r_sy10;
    logic [15:0]          r_sy11;
    logic signed [D_W-1:0] r_top;
    logic signed [D_W-1:0] r_bot;
    logic signed [M_W-1:0] r_py;
    logic signed [D_W-1:0] r_top12;
    logic signed [D_W-1:0] r_n;
    logic signed [CH_W-1:0] r_ch_r;
    logic signed [CH_W-1:0] r_ch_g;
    logic signed [CH_W-1:0] r_ch_b;
    gnpc_pkg::t_result    r_res;

    logic                 en;
    logic [7:0]           x0;
    logic [7:0]           y0;
    logic [15:0]          tx;
    logic [15:0]          ty;
    logic [8:0]           x0e;
    logic [8:0]           y0e;
    logic [8:0]           x1e;
    logic [8:0]           y1e;
    logic signed [16:0]   dxn;
    logic signed [16:0]   dxf;
    logic signed [16:0]   dyn;
    logic signed [16:0]   dyf;
    logic signed [D_W-1:0] dot00;
    logic signed [D_W-1:0] dot10;
    logic signed [D_W-1:0] dot01;
    logic signed [D_W-1:0] dot11;
    logic [49:0]          smx;
    logic [49:0]          smy;
    logic [15:0]          sx9;
    logic [15:0]          sy9;
    logic signed [D_W:0]  base;

    // floor to a colour byte, clamped to the byte range
    function automatic logic [gnpc_pkg::COLOR_W-1:0] clamp(
            input logic signed [CH_W-1:0] v);
        logic signed [CH_W-1:0] sh;
        sh = v >>> (FRAC_BITS + 1);
        if (v < 0) begin
            return '0;
        end
        if (sh > $signed(CH_W'(COLOR_MAX))) begin
            return COLOR_MAX;
        end
        return sh[gnpc_pkg::COLOR_W-1:0];
    endfunction

    assign en      = !r_v[LAST] || i_ready;
    assign o_pop   = en && i_valid;
    assign o_valid = r_v[LAST];
    assign o_result = r_res;

    // cell indices and corner offsets
    assign x0  = r_lat.coord_x[23:16];
    assign y0  = r_lat.coord_y[23:16];
    assign tx  = r_lat.coord_x[15:0];
    assign ty  = r_lat.coord_y[15:0];
    assign x0e = {1'b0, x0};
    assign y0e = {1'b0, y0};
    assign x1e = x0e + 9'd1;
    assign y1e = y0e + 9'd1;
    assign dxn = $signed({1'b0, tx});
    assign dxf = $signed({1'b1, tx});
    assign dyn = $signed({1'b0, ty});
    assign dyf = $signed({1'b1, ty});

    gnpc_corner #(.FRAC_BITS(FRAC_BITS)) u_c00 (
        .i_clk(i_clk), .i_en(en), .i_cell_x(x0e), .i_cell_y(y0e),
        .i_dx(dxn), .i_dy(dyn), .i_seed(i_cfg.hash_seed), .o_dot(dot00));
    gnpc_corner #(.FRAC_BITS(FRAC_BITS)) u_c10 (
        .i_clk(i_clk), .i_en(en), .i_cell_x(x1e), .i_cell_y(y0e),
        .i_dx(dxf), .i_dy(dyn), .i_seed(i_cfg.hash_seed), .o_dot(dot10));
    gnpc_corner #(.FRAC_BITS(FRAC_BITS)) u_c01 (
        .i_clk(i_clk), .i_en(en), .i_cell_x(x0e), .i_cell_y(y1e),
        .i_dx(dxn), .i_dy(dyf), .i_seed(i_cfg.hash_seed), .o_dot(dot01));
    gnpc_corner #(.FRAC_BITS(FRAC_BITS)) u_c11 (
        .i_clk(i_clk), .i_en(en), .i_cell_x(x1e), .i_cell_y(y1e),
        .i_dx(dxf), .i_dy(dyf), .i_seed(i_cfg.hash_seed), .o_dot(dot11));

    // smoothstep second product and channel base
    assign smx  = 50'(r_ttx) * 50'(18'(196608) - {1'b0, r_tx1, 1'b0});
    assign smy  = 50'(r_tty) * 50'(18'(196608) - {1'b0, r_ty1, 1'b0});
    assign sx9  = r_s[SD-1][31:16];
    assign sy9  = r_s[SD-1][15:0];
    assign base = NOISE_ONE - (D_W+1)'(r_n);

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lat   <= i_lat;
            r_ttx   <= 32'(tx) * 32'(tx);
            r_tty   <= 32'(ty) * 32'(ty);
            r_tx1   <= tx;
            r_ty1   <= ty;
            r_s[0]  <= {smx[47:32], smy[47:32]};
            for (int i = 1; i < SD; i++) begin
                r_s[i] <= r_s[i-1];
            end
            // blend along x
            r_pt    <= ((D_W+1)'(dot10) - (D_W+1)'(dot00)) * $signed({1'b0, sx9});
            r_pb    <= ((D_W+1)'(dot11) - (D_W+1)'(dot01)) * $signed({1'b0, sx9});
            r_at    <= dot00;
            r_ab    <= dot01;
            r_sy10  <= sy9;
            r_top   <= D_W'((D_W+2)'(r_at) + (D_W+2)'(r_pt >>> 16));
            r_bot   <= D_W'((D_W+2)'(r_ab) + (D_W+2)'(r_pb >>> 16));
            r_sy11  <= r_sy10;
            // blend along y
            r_py    <= ((D_W+1)'(r_bot) - (D_W+1)'(r_top)) * $signed({1'b0, r_sy11});
            r_top12 <= r_top;
            r_n     <= D_W'((D_W+2)'(r_top12) + (D_W+2)'(r_py >>> 16));
            // colour mapping
            r_ch_r  <= base * $signed({1'b0, i_cfg.red_level});
            r_ch_g  <= base * $signed({1'b0, i_cfg.green_level});
            r_ch_b  <= base * $signed({1'b0, i_cfg.blue_level});
            r_res.red_out   <= clamp(r_ch_r);
            r_res.green_out <= clamp(r_ch_g);
            r_res.blue_out  <= clamp(r_ch_b);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= LAST; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= LAST; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

endmodule
`default_nettype wire

>>> src/gradient_noise_pixel_colorizer_unit.sv
// throughput: one pixel per cycle unless a full result queue stalls the pipes, set by
//   the two-bit-per-stage divider pipe and the fully pipelined corner units
// reset: registers return to their defaults, all queues and pipes empty
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_noise_pixel_colorizer_unit
// 2-D gradient noise colorizer: pixel coordinate in, RGB word out, with an
// APB register port for image size, zoom, seed and channel levels.
// ----------------------------------------------------------------------------
module gradient_noise_pixel_colorizer_unit #(
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned FRAC_BITS  = 15
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire gnpc_pkg::t_pixel              i_pixel,
    output logic                               empty,
    input  wire logic                          pop,
    output gnpc_pkg::t_result                  o_result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gnpc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [gnpc_pkg::DATA_W-1:0]   pwdata,
    output logic [gnpc_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    localparam int unsigned LAT_WORD_W = $bits(gnpc_pkg::t_lat);
    localparam int unsigned RES_WORD_W = $bits(gnpc_pkg::t_result);

    gnpc_pkg::t_cfg    r_cfg;
    gnpc_pkg::t_reg_idx reg_idx;
    logic              wr_en;

    logic              front_ready;
    logic              front_valid;
    gnpc_pkg::t_lat    front_lat;
    logic              mid_full;
    logic              mid_empty;
    logic              mid_pop;
    gnpc_pkg::t_lat    mid_lat;
    logic              back_valid;
    gnpc_pkg::t_result back_res;
    logic              out_full;

    // register port
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = gnpc_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= gnpc_pkg::RST_IMAGE_WIDTH;
            r_cfg.image_height <= gnpc_pkg::RST_IMAGE_HEIGHT;
            r_cfg.zoom_q8_8    <= gnpc_pkg::RST_ZOOM;
            r_cfg.hash_seed    <= gnpc_pkg::RST_HASH_SEED;
            r_cfg.red_level    <= gnpc_pkg::RST_LEVEL;
            r_cfg.green_level  <= gnpc_pkg::RST_LEVEL;
            r_cfg.blue_level   <= gnpc_pkg::RST_LEVEL;
        end else if (wr_en) begin
            case (reg_idx)
                gnpc_pkg::REG_IMAGE_WIDTH:  r_cfg.image_width  <= pwdata[gnpc_pkg::SIZE_W-1:0];
                gnpc_pkg::REG_IMAGE_HEIGHT: r_cfg.image_height <= pwdata[gnpc_pkg::SIZE_W-1:0];
                gnpc_pkg::REG_ZOOM:         r_cfg.zoom_q8_8    <= pwdata[gnpc_pkg::ZOOM_W-1:0];
                gnpc_pkg::REG_HASH_SEED:    r_cfg.hash_seed    <= pwdata[gnpc_pkg::SEED_W-1:0];
                gnpc_pkg::REG_RED_LEVEL:    r_cfg.red_level    <= pwdata[gnpc_pkg::LEVEL_W-1:0];
                gnpc_pkg::REG_GREEN_LEVEL:  r_cfg.green_level  <= pwdata[gnpc_pkg::LEVEL_W-1:0];
                gnpc_pkg::REG_BLUE_LEVEL:   r_cfg.blue_level   <= pwdata[gnpc_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            gnpc_pkg::REG_IMAGE_WIDTH:  prdata = gnpc_pkg::DATA_W'(r_cfg.image_width);
            gnpc_pkg::REG_IMAGE_HEIGHT: prdata = gnpc_pkg::DATA_W'(r_cfg.image_height);
            gnpc_pkg::REG_ZOOM:         prdata = gnpc_pkg::DATA_W'(r_cfg.zoom_q8_8);
            gnpc_pkg::REG_HASH_SEED:    prdata = gnpc_pkg::DATA_W'(r_cfg.hash_seed);
            gnpc_pkg::REG_RED_LEVEL:    prdata = gnpc_pkg::DATA_W'(r_cfg.red_level);
            gnpc_pkg::REG_GREEN_LEVEL:  prdata = gnpc_pkg::DATA_W'(r_cfg.green_level);
            gnpc_pkg::REG_BLUE_LEVEL:   prdata = gnpc_pkg::DATA_W'(r_cfg.blue_level);
            default:                    prdata = '0;
        endcase
    end

    // front: lattice scaling
    assign full = !front_ready;

    gnpc_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (push),
        .o_ready (front_ready),
        .i_pixel (i_pixel),
        .i_cfg   (r_cfg),
        .o_valid (front_valid),
        .i_ready (!mid_full),
        .o_lat   (front_lat)
    );

    // queue between front and back
    gnpc_fifo #(.W(LAT_WORD_W), .DEPTH(4)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_lat),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_lat),
        .o_empty (mid_empty)
    );

    // back: noise and colour
    gnpc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!mid_empty),
        .o_pop    (mid_pop),
        .i_lat    (mid_lat),
        .i_cfg    (r_cfg),
        .o_valid  (back_valid),
        .i_ready  (!out_full),
        .o_result (back_res)
    );

    // result queue
    gnpc_fifo #(.W(RES_WORD_W), .DEPTH(2)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_valid),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule
`default_nettype wire

>>> src/gnpc_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnpc_check
// Port-level checker for the colorizer: tracks words in flight and checks
// the queue sides against it.
// ----------------------------------------------------------------------------
module gnpc_check (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        push,
    input wire logic                        full,
    input wire gnpc_pkg::t_pixel            i_pixel,
    input wire logic                        empty,
    input wire logic                        pop,
    input wire gnpc_pkg::t_result           o_result,
    input wire logic                        psel,
    input wire logic                        penable,
    input wire logic                        pwrite,
    input wire logic [gnpc_pkg::ADDR_W-1:0] paddr,
    input wire logic [gnpc_pkg::DATA_W-1:0] pwdata,
    input wire logic [gnpc_pkg::DATA_W-1:0] prdata,
    input wire logic                        pready
);
    localparam logic [7:0] FLIGHT_MAX = 8'd64;

    logic [7:0] r_cnt;
    logic       acc_in;
    logic       acc_out;

    assign acc_in  = push && !full;
    assign acc_out = pop && !empty;

    // words accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (acc_in && !acc_out) begin
            r_cnt <= r_cnt + 8'd1;
        end else if (acc_out && !acc_in) begin
            r_cnt <= r_cnt - 8'd1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> r_cnt != 8'd0)
        else $error("result word shown with nothing in flight");

    a_idle_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 8'd0 |-> !full)
        else $error("input side full while the block holds nothing");

    a_flight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FLIGHT_MAX)
        else $error("more words in flight than the pipes can hold");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result word changed or vanished");

endmodule

bind gradient_noise_pixel_colorizer_unit gnpc_check u_check (.*);
`default_nettype wire

>>> tb/gnpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnpc_checker
// Watches the pixel and color channels and the register port of the noise
// colorizer, computes the expected color of every accepted pixel and compares
// it field by field with the words that leave the block.
// ----------------------------------------------------------------------------
module gnpc_checker
    import gnpc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    push,
    input  wire logic    full,
    input  wire t_pixel  i_pixel,
    input  wire logic    empty,
    input  wire logic    pop,
    input  wire t_result o_result,
    input  wire logic    psel,
    input  wire logic    penable,
    input  wire logic    pwrite,
    input  wire logic    pready,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output int           o_errors,
    output int           o_pending,
    output int           o_colors_seen
);

    localparam int FRAC = 15;

    t_cfg    shadow_cfg;
    t_result color_queue[$];
    longint  sin_tab[0:90];

    // quarter-wave sine magnitude, Taylor series in Q30
    initial begin
        longint unsigned x, x2, term, acc, r;
        for (int k = 0; k <= 90; k++) begin
            x = (64'(k) * 64'd3373259426) / 64'd180;
            x2 = (x * x) >> 30;
            term = x;
            acc = x;
            for (int n = 1; n <= 6; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) acc = acc - term;
                else acc = acc + term;
            end
            r = (acc + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
            if (r > (64'd1 << FRAC) - 1) r = (64'd1 << FRAC) - 1;
            sin_tab[k] = longint'(r);
        end
    end

    function automatic longint floor_div(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sine_deg(int unsigned a);
        a = a % 360;
        if (a <= 90) return sin_tab[a];
        if (a <= 180) return sin_tab[180 - a];
        if (a <= 270) return -sin_tab[a - 180];
        return -sin_tab[360 - a];
    endfunction

    function automatic longint gradient_dot(logic [31:0] cx, logic [31:0] cy,
                                            longint dx, longint dy);
        logic [31:0] h;
        int unsigned ang;
        h = cx * HASH_MUL_X + cy * HASH_MUL_Y + shadow_cfg.hash_seed;
        h = (h ^ (h >> 13)) * HASH_MIX;
        h = h ^ (h >> 16);
        ang = h % 360;
        return floor_div(sine_deg(ang + 90) * dx + sine_deg(ang) * dy, 16);
    endfunction

    function automatic logic [23:0] lattice_coord(logic [11:0] pix,
                                                  logic [12:0] size);
        longint unsigned num;
        num = (64'(pix) * 64'(shadow_cfg.zoom_q8_8)) << 8;
        return 24'(num / ((size == 0) ? 64'd1 : 64'(size)));
    endfunction

    function automatic longint ease(longint t);
        return longint'((64'(t * t) * 64'(3 * 65536 - 2 * t)) >> 32);
    endfunction

    function automatic longint lerp(longint a, longint b, longint s);
        return a + floor_div((b - a) * s, 16);
    endfunction

    function automatic logic [7:0] shade(longint n, logic [7:0] level);
        longint v;
        v = ((longint'(1) << FRAC) - n) * longint'(level);
        if (v < 0) return 8'd0;
        v = v >> (FRAC + 1);
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    function automatic t_result noise_color(t_pixel p);
        logic [23:0] cx, cy;
        logic [31:0] x0, y0;
        longint tx, ty, sx, sy, top, bot, n;
        t_result c;
        cx = lattice_coord(p.pixel_x, shadow_cfg.image_width);
        cy = lattice_coord(p.pixel_y, shadow_cfg.image_height);
        x0 = 32'(cx >> 16);
        y0 = 32'(cy >> 16);
        tx = longint'(cx[15:0]);
        ty = longint'(cy[15:0]);
        sx = ease(tx);
        sy = ease(ty);
        top = lerp(gradient_dot(x0, y0, tx, ty),
                   gradient_dot(x0 + 1, y0, tx - 65536, ty), sx);
        bot = lerp(gradient_dot(x0, y0 + 1, tx, ty - 65536),
                   gradient_dot(x0 + 1, y0 + 1, tx - 65536, ty - 65536), sx);
        n = lerp(top, bot, sy);
        c.red_out = shade(n, shadow_cfg.red_level);
        c.green_out = shade(n, shadow_cfg.green_level);
        c.blue_out = shade(n, shadow_cfg.blue_level);
        return c;
    endfunction

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        $display("[%0t] color word %0d: %s got %0d want %0d",
                 $realtime, o_colors_seen, what, got, want);
        o_errors++;
    endtask

    // register shadow, prediction on push, compare on pop
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            shadow_cfg.image_width <= RST_IMAGE_WIDTH;
            shadow_cfg.image_height <= RST_IMAGE_HEIGHT;
            shadow_cfg.zoom_q8_8 <= RST_ZOOM;
            shadow_cfg.hash_seed <= RST_HASH_SEED;
            shadow_cfg.red_level <= RST_LEVEL;
            shadow_cfg.green_level <= RST_LEVEL;
            shadow_cfg.blue_level <= RST_LEVEL;
            color_queue.delete();
            o_errors <= 0;
            o_colors_seen <= 0;
            o_pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_IMAGE_WIDTH:  shadow_cfg.image_width <= pwdata[12:0];
                    REG_IMAGE_HEIGHT: shadow_cfg.image_height <= pwdata[12:0];
                    REG_ZOOM:         shadow_cfg.zoom_q8_8 <= pwdata[15:0];
                    REG_HASH_SEED:    shadow_cfg.hash_seed <= pwdata;
                    REG_RED_LEVEL:    shadow_cfg.red_level <= pwdata[7:0];
                    REG_GREEN_LEVEL:  shadow_cfg.green_level <= pwdata[7:0];
                    REG_BLUE_LEVEL:   shadow_cfg.blue_level <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (push && !full) color_queue.push_back(noise_color(i_pixel));
            if (pop && !empty) begin
                if (color_queue.size() == 0) begin
                    $display("[%0t] color word with no pixel waiting", $realtime);
                    o_errors++;
                end else begin
                    want = color_queue.pop_front();
                    if (o_result.red_out !== want.red_out)
                        report("red", o_result.red_out, want.red_out);
                    if (o_result.green_out !== want.green_out)
                        report("green", o_result.green_out, want.green_out);
                    if (o_result.blue_out !== want.blue_out)
                        report("blue", o_result.blue_out, want.blue_out);
                end
                o_colors_seen++;
            end
            // predictions still waiting for their word
            o_pending <= color_queue.size();
        end
    end

endmodule

>>> tb/tb_gradient_noise_pixel_colorizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gradient_noise_pixel_colorizer_unit
// Drives pixel words with random gaps and a randomly stalling color sink
// through several register settings; the checker predicts every color.
// ----------------------------------------------------------------------------
module tb_gradient_noise_pixel_colorizer_unit;
    import gnpc_pkg::*;

    localparam longint CYCLE_LIMIT = 400000;
    localparam int     DRAIN = 60;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    t_pixel i_pixel = '0;
    logic empty;
    logic pop = 1'b0;
    t_result o_result;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    int errors, pending, colors_seen;
    longint cycles = 0;
    int pixels_sent = 0;
    logic [12:0] cur_w = 13'd256, cur_h = 13'd256;

    always #4 i_clk = ~i_clk;

    gradient_noise_pixel_colorizer_unit uut (.*);

    gnpc_checker checker_i (.*, .o_errors(errors), .o_pending(pending),
                            .o_colors_seen(colors_seen));

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("gradient_noise_pixel_colorizer_unit: mismatch");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // color sink with random stalls
    initial begin
        int g;
        @(posedge i_clk iff i_rst_n);
        forever begin
            g = gap_len();
            if (g > 0) begin
                pop <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk iff !empty);
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk iff pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_IMAGE_WIDTH) cur_w = val[12:0];
        if (idx == REG_IMAGE_HEIGHT) cur_h = val[12:0];
    endtask

    task automatic send_pixel(logic [11:0] x, logic [11:0] y);
        int g;
        g = gap_len();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        push <= 1'b1;
        i_pixel <= '{pixel_x: x, pixel_y: y};
        @(posedge i_clk iff !full);
        pixels_sent++;
    endtask

    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // mostly in-image coordinates, some anywhere in the field
    task automatic random_pixels(int count);
        logic [11:0] x, y;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 8) begin
                x = 12'($urandom_range(0, (cur_w == 0) ? 0 : cur_w - 1));
                y = 12'($urandom_range(0, (cur_h == 0) ? 0 : cur_h - 1));
            end else begin
                x = 12'($urandom);
                y = 12'($urandom);
            end
            send_pixel(x, y);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: corners of the field, lattice edges, reset settings
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd255, 12'd0);
        send_pixel(12'd0, 12'd255);
        send_pixel(12'd256, 12'd256);
        send_pixel(12'd2730, 12'd1365);
        send_pixel(12'd8, 12'd16);
        settle();

        // zero sizes divide as one, max zoom wraps the coordinate
        write_reg(REG_IMAGE_WIDTH, 32'd0);
        write_reg(REG_IMAGE_HEIGHT, 32'hFFFF_E000);
        write_reg(REG_ZOOM, 32'd65535);
        write_reg(REG_HASH_SEED, 32'hFFFF_FFFF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd4095);
        send_pixel(12'd4095, 12'd1);
        send_pixel(12'd2048, 12'd3000);
        settle();

        // zero zoom, zero and mixed levels, widest size
        write_reg(REG_ZOOM, 32'd0);
        write_reg(REG_RED_LEVEL, 32'd0);
        write_reg(REG_GREEN_LEVEL, 32'd128);
        write_reg(REG_BLUE_LEVEL, 32'hFFFF_FF7F);
        write_reg(REG_IMAGE_WIDTH, 32'd4096);
        write_reg(REG_IMAGE_HEIGHT, 32'd8191);
        send_pixel(12'd100, 12'd200);
        send_pixel(12'd4095, 12'd0);
        settle();
        write_reg(REG_ZOOM, 32'd1);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1234, 12'd777);
        settle();

        // random phases through several settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_IMAGE_WIDTH, (ph == 0) ? 32'd1 : $urandom_range(1, 4096));
            write_reg(REG_IMAGE_HEIGHT, (ph == 1) ? 32'd4096 : $urandom_range(1, 4096));
            write_reg(REG_ZOOM, (ph == 2) ? 32'd65535 : $urandom_range(1, 8192));
            write_reg(REG_HASH_SEED, $urandom);
            write_reg(REG_RED_LEVEL, (ph == 3) ? 32'd255 : $urandom_range(0, 255));
            write_reg(REG_GREEN_LEVEL, $urandom_range(0, 255));
            write_reg(REG_BLUE_LEVEL, (ph == 4) ? 32'd0 : $urandom_range(0, 255));
            random_pixels(135);
            settle();
        end

        $display("run covered %0d pixels and %0d color words over 12 register settings",
                 pixels_sent, colors_seen);
        if (errors == 0) begin
            $display("gradient_noise_pixel_colorizer_unit: match");
        end else begin
            $display("gradient_noise_pixel_colorizer_unit: mismatch");
        end
        $finish;
    end

endmodule
